@@ src/crdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel/region descriptor parser package
// Shared constants, register indexes and the records passed between the
// front end, the internal queue and the parse engine.
// ----------------------------------------------------------------------------
package crdp_pkg;

  // Default depth of the internal and result queues.
  localparam int unsigned QueueDepth = 2;

  // Reset values of the descriptor tag registers.
  localparam logic [7:0] ChannelTagReset = 8'hd3;
  localparam logic [7:0] RegionTagReset  = 8'hd4;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CHANNEL_TAG = 1'b0,
    REG_REGION_TAG  = 1'b1
  } reg_idx_e;

  // Descriptor class decided by the front end on a first byte.
  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_CHANNEL = 2'd1,
    CLS_REGION  = 2'd2
  } desc_class_e;

  // Kind of an emitted record.
  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_EMPTY   = 2'd2
  } record_kind_e;

  // One classified payload byte.
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  len;
    desc_class_e cls;
    logic        first;
  } item_t;

  // One emitted record.
  typedef struct packed {
    record_kind_e kind;
    logic [15:0]  service_id;
    logic [11:0]  channel_number;
    logic [15:0]  region_code;
    logic [15:0]  region_id;
    logic [7:0]   name_char;
    logic         name_last;
  } result_t;

endpackage

@@ src/channel_region_descriptor_parser.sv @@
`timescale 1ns / 1ps
// Path: a byte that yields a record is written into the internal queue, is
// parsed from its head and has its record written into the result queue,
// where it can be popped; a full result queue holds it in the internal queue.
// Throughput: one byte per cycle, sustained while results are popped; the parse
// engine takes one queued byte per cycle while the result queue has room.
// Reset: asynchronous, active low; clears queues and parse state and loads
// the tag registers with 0xd3 (channel list) and 0xd4 (region names).
// ----------------------------------------------------------------------------
// Channel/region descriptor parser
// Top level: front end with tag registers, internal queue, parse engine
// and result queue.
// ----------------------------------------------------------------------------
module channel_region_descriptor_parser #(
  parameter int unsigned QUEUE_DEPTH  = crdp_pkg::QueueDepth,
  parameter int unsigned RESULT_DEPTH = crdp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  desc_tag_i,
  input  logic [7:0]  desc_length_i,
  input  logic        first_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  record_kind_o,
  output logic [15:0] service_id_o,
  output logic [11:0] channel_number_o,
  output logic [15:0] region_code_o,
  output logic [15:0] region_id_o,
  output logic [7:0]  name_char_o,
  output logic        name_last_o
);

  localparam int unsigned ItemW = $bits(crdp_pkg::item_t);
  localparam int unsigned ResW  = $bits(crdp_pkg::result_t);

  crdp_pkg::item_t   front_item;
  crdp_pkg::item_t   back_item;
  crdp_pkg::result_t back_res;
  crdp_pkg::result_t out_res;
  logic              q_wr, q_full, q_empty, q_rd;
  logic              res_push, res_full;
  logic [ItemW-1:0]  q_rd_data;
  logic [ResW-1:0]   res_rd_data;

  // Front end: tag registers and classification.
  crdp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .q_full_i      (q_full),
    .data_byte_i   (data_byte_i),
    .desc_tag_i    (desc_tag_i),
    .desc_length_i (desc_length_i),
    .first_byte_i  (first_byte_i),
    .q_wr_o        (q_wr),
    .item_o        (front_item)
  );

  assign full = q_full;

  // Queue between front end and parse engine.
  crdp_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (front_item),
    .rd_en_i   (q_rd),
    .rd_data_o (q_rd_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  assign back_item = crdp_pkg::item_t'(q_rd_data);

  // Parse engine.
  crdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (!q_empty),
    .out_full_i   (res_full),
    .item_pop_o   (q_rd),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // Result queue toward the consumer.
  crdp_fifo #(
    .WIDTH (ResW),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (back_res),
    .rd_en_i   (pop),
    .rd_data_o (res_rd_data),
    .full_o    (res_full),
    .empty_o   (empty)
  );

  // Result fields.
  assign out_res          = crdp_pkg::result_t'(res_rd_data);
  assign record_kind_o    = out_res.kind;
  assign service_id_o     = out_res.service_id;
  assign channel_number_o = out_res.channel_number;
  assign region_code_o    = out_res.region_code;
  assign region_id_o      = out_res.region_id;
  assign name_char_o      = out_res.name_char;
  assign name_last_o      = out_res.name_last;

endmodule

@@ src/crdp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module crdp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = crdp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ src/crdp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor parser front end
// Holds the tag registers, accepts payload bytes and classifies each
// descriptor by its tag on the first byte.
// ----------------------------------------------------------------------------
module crdp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  push,
  input  logic                  q_full_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            desc_tag_i,
  input  logic [7:0]            desc_length_i,
  input  logic                  first_byte_i,
  output logic                  q_wr_o,
  output crdp_pkg::item_t       item_o
);

  logic [7:0] chan_tag_q;
  logic [7:0] region_tag_q;

  // Tag registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_tag_q   <= crdp_pkg::ChannelTagReset;
      region_tag_q <= crdp_pkg::RegionTagReset;
    end else if (cfg_we_i) begin
      unique case (crdp_pkg::reg_idx_e'(cfg_idx_i))
        crdp_pkg::REG_CHANNEL_TAG: chan_tag_q   <= cfg_data_i;
        crdp_pkg::REG_REGION_TAG:  region_tag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classification; a channel match wins when both tags are equal.
  always_comb begin
    item_o.data  = data_byte_i;
    item_o.len   = desc_length_i;
    item_o.first = first_byte_i;
    priority if (desc_tag_i == chan_tag_q) begin
      item_o.cls = crdp_pkg::CLS_CHANNEL;
    end else if (desc_tag_i == region_tag_q) begin
      item_o.cls = crdp_pkg::CLS_REGION;
    end else begin
      item_o.cls = crdp_pkg::CLS_NONE;
    end
  end

  assign q_wr_o = push && !q_full_i;

endmodule

@@ src/crdp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor parser engine
// Walks group headers, channel entries and region names one byte per cycle
// while the result queue has room and produces at most one record per byte.
// ----------------------------------------------------------------------------
module crdp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crdp_pkg::item_t       item_i,
  input  logic                  item_valid_i,
  input  logic                  out_full_i,
  output logic                  item_pop_o,
  output logic                  res_push_o,
  output crdp_pkg::result_t     res_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhChHdr  = 3'd1;
  localparam logic [2:0] PhChEnt  = 3'd2;
  localparam logic [2:0] PhRgHdr  = 3'd3;
  localparam logic [2:0] PhRgName = 3'd4;

  localparam logic [2:0] ChLenPos = 3'd4;
  localparam logic [2:0] RgLenPos = 3'd5;
  localparam logic [1:0] EntLast  = 2'd3;

  logic [2:0]  phase_q, phase_d, phase_v;
  logic [2:0]  hdr_pos_q, hdr_pos_d, hdr_pos_v;
  logic [7:0]  desc_left_q, desc_left_d, desc_left_v, left_dec;
  logic [7:0]  grp_left_q, grp_left_d, grp_left_v, grp_dec;
  logic [1:0]  ent_pos_q, ent_pos_d, ent_pos_v;
  logic [15:0] sid_q, sid_d;
  logic [15:0] rid_q, rid_d;
  logic [23:0] ebytes_q, ebytes_d;
  logic        res_valid;
  logic [7:0]  b;

  // The engine advances whenever a byte is waiting and a result has room.
  assign item_pop_o = item_valid_i && !out_full_i;
  assign res_push_o = item_pop_o && res_valid;
  assign b          = item_i.data;

  // Next-state and record logic for one byte.
  always_comb begin
    phase_v     = phase_q;
    hdr_pos_v   = hdr_pos_q;
    desc_left_v = desc_left_q;
    grp_left_v  = grp_left_q;
    ent_pos_v   = ent_pos_q;
    if (item_i.first) begin
      desc_left_v = item_i.len;
      hdr_pos_v   = '0;
      ent_pos_v   = '0;
      grp_left_v  = '0;
      unique case (item_i.cls)
        crdp_pkg::CLS_CHANNEL: phase_v = PhChHdr;
        crdp_pkg::CLS_REGION:  phase_v = PhRgHdr;
        default:               phase_v = PhIdle;
      endcase
    end

    left_dec = desc_left_v - 8'd1;
    grp_dec  = grp_left_v - 8'd1;

    phase_d     = phase_v;
    hdr_pos_d   = hdr_pos_v;
    desc_left_d = desc_left_v;
    grp_left_d  = grp_left_v;
    ent_pos_d   = ent_pos_v;
    sid_d       = sid_q;
    rid_d       = rid_q;
    ebytes_d    = ebytes_q;
    res_valid   = 1'b0;
    res_o       = '0;

    if (desc_left_v == '0) begin
      // Byte beyond the descriptor payload.
      phase_d = PhIdle;
    end else begin
      desc_left_d = left_dec;
      unique case (phase_v)
        PhChHdr: begin
          if (hdr_pos_v == ChLenPos) begin
            hdr_pos_d = '0;
            if (b > left_dec) begin
              phase_d = PhIdle;
            end else if (b != '0) begin
              grp_left_d = b;
              ent_pos_d  = '0;
              phase_d    = PhChEnt;
            end
          end else begin
            if (hdr_pos_v == 3'd0) begin
              sid_d = {b, 8'h00};
            end else if (hdr_pos_v == 3'd1) begin
              sid_d = {sid_q[15:8], b};
            end
            hdr_pos_d = hdr_pos_v + 3'd1;
          end
        end
        PhChEnt: begin
          grp_left_d = grp_dec;
          if (ent_pos_v == EntLast) begin
            res_valid            = 1'b1;
            res_o.kind           = crdp_pkg::KIND_CHANNEL;
            res_o.service_id     = sid_q;
            res_o.channel_number = ebytes_q[19:8];
            res_o.region_code    = {ebytes_q[7:0], b};
            ent_pos_d            = '0;
          end else begin
            ebytes_d  = {ebytes_q[15:0], b};
            ent_pos_d = ent_pos_v + 2'd1;
          end
          // End of the loop drops any partial entry.
          if (grp_dec == '0) begin
            ent_pos_d = '0;
            hdr_pos_d = '0;
            phase_d   = PhChHdr;
          end
        end
        PhRgHdr: begin
          if (hdr_pos_v == RgLenPos) begin
            hdr_pos_d = '0;
            if (b > left_dec) begin
              phase_d = PhIdle;
            end else if (b == '0) begin
              res_valid       = 1'b1;
              res_o.kind      = crdp_pkg::KIND_EMPTY;
              res_o.region_id = rid_q;
              res_o.name_last = 1'b1;
            end else begin
              grp_left_d = b;
              phase_d    = PhRgName;
            end
          end else begin
            if (hdr_pos_v == 3'd0) begin
              rid_d = {b, 8'h00};
            end else if (hdr_pos_v == 3'd1) begin
              rid_d = {rid_q[15:8], b};
            end
            hdr_pos_d = hdr_pos_v + 3'd1;
          end
        end
        PhRgName: begin
          grp_left_d      = grp_dec;
          res_valid       = 1'b1;
          res_o.kind      = crdp_pkg::KIND_NAME;
          res_o.region_id = rid_q;
          res_o.name_char = b;
          res_o.name_last = (grp_dec == '0);
          if (grp_dec == '0) begin
            hdr_pos_d = '0;
            phase_d   = PhRgHdr;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hdr_pos_q   <= '0;
      desc_left_q <= '0;
      grp_left_q  <= '0;
      ent_pos_q   <= '0;
      sid_q       <= '0;
      rid_q       <= '0;
      ebytes_q    <= '0;
    end else if (item_pop_o) begin
      phase_q     <= phase_d;
      hdr_pos_q   <= hdr_pos_d;
      desc_left_q <= desc_left_d;
      grp_left_q  <= grp_left_d;
      ent_pos_q   <= ent_pos_d;
      sid_q       <= sid_d;
      rid_q       <= rid_d;
      ebytes_q    <= ebytes_d;
    end
  end

  // A record is only produced for a byte that is consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> item_pop_o)
    else $error("record pushed without consuming a byte");

  // A channel record always closes its entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == crdp_pkg::KIND_CHANNEL) |=> (ent_pos_q == '0))
    else $error("entry position not cleared after a channel record");

  // Without a new descriptor the remaining byte count never grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && !item_i.first) |=> (desc_left_q <= $past(desc_left_q)))
    else $error("descriptor byte count grew inside a descriptor");

  // Inside a loop or a name there is always at least one byte left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhChEnt || phase_q == PhRgName) |-> (grp_left_q != '0))
    else $error("group byte count empty inside a group");

endmodule

@@ tb/sv/tb_channel_region_descriptor_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel/region descriptor parser testbench
// Feeds descriptor payload bytes through the push/full request queue. A
// scoreboard class carries its own model of the parser and keeps the records
// that the block still owes. Every popped record is checked field by field.
// The run starts with a short directed sequence. It then sends random
// descriptors under several tag register settings, with random sender
// bursts and receiver stalls.
// ----------------------------------------------------------------------------

// Parser phases of the prediction model.
typedef enum logic [2:0] {
  ST_SKIP,
  ST_CH_HEAD,
  ST_CH_ENTRY,
  ST_RG_HEAD,
  ST_RG_NAME
} parse_state_e;

// One payload byte request as driven on the input ports.
typedef struct packed {
  logic [7:0] data;
  logic [7:0] tag;
  logic [7:0] len;
  logic       first;
} desc_byte_t;

// Descriptor parse model plus the queue of records still owed by the block.
class descriptor_scoreboard;
  logic [7:0]         channel_tag;
  logic [7:0]         region_tag;
  parse_state_e       state;
  logic [2:0]         hdr_pos;
  logic [7:0]         bytes_left;
  logic [7:0]         group_left;
  logic [1:0]         entry_pos;
  logic [15:0]        service;
  logic [15:0]        region;
  logic [23:0]        entry_buf;
  crdp_pkg::result_t  records_due[$];
  int unsigned        errors;
  int unsigned        records_checked;

  function new();
    channel_tag     = crdp_pkg::ChannelTagReset;
    region_tag      = crdp_pkg::RegionTagReset;
    state           = ST_SKIP;
    hdr_pos         = '0;
    bytes_left      = '0;
    group_left      = '0;
    entry_pos       = '0;
    service         = '0;
    region          = '0;
    entry_buf       = '0;
    errors          = 0;
    records_checked = 0;
  endfunction

  function void set_tag(crdp_pkg::reg_idx_e idx, logic [7:0] value);
    if (idx == crdp_pkg::REG_CHANNEL_TAG) channel_tag = value;
    else region_tag = value;
  endfunction

  function int pending();
    return records_due.size();
  endfunction

  // Advances the parse model by one byte; returns 1 when a record comes out.
  function bit parse_byte(desc_byte_t it, output crdp_pkg::result_t rec);
    logic [7:0] b;
    b   = it.data;
    rec = '0;
    // A first byte restarts the descriptor and picks its class by tag.
    if (it.first) begin
      bytes_left = it.len;
      hdr_pos    = '0;
      entry_pos  = '0;
      group_left = '0;
      if (it.tag == channel_tag) state = ST_CH_HEAD;
      else if (it.tag == region_tag) state = ST_RG_HEAD;
      else state = ST_SKIP;
    end
    if (bytes_left == 0) begin
      state = ST_SKIP;
      return 1'b0;
    end
    bytes_left = bytes_left - 8'd1;

    case (state)
      ST_CH_HEAD: begin
        // Service id, two skipped bytes, then the loop length.
        if (hdr_pos == 3'd4) begin
          hdr_pos = '0;
          if (b > bytes_left) begin
            state = ST_SKIP;
          end else if (b != 0) begin
            group_left = b;
            entry_pos  = '0;
            state      = ST_CH_ENTRY;
          end
          return 1'b0;
        end
        if (hdr_pos == 3'd0) service = {b, 8'h00};
        else if (hdr_pos == 3'd1) service[7:0] = b;
        hdr_pos = hdr_pos + 3'd1;
        return 1'b0;
      end
      ST_CH_ENTRY: begin
        bit produced;
        produced   = 1'b0;
        group_left = group_left - 8'd1;
        if (entry_pos == 2'd3) begin
          rec.kind           = crdp_pkg::KIND_CHANNEL;
          rec.service_id     = service;
          rec.channel_number = entry_buf[19:8];
          rec.region_code    = {entry_buf[7:0], b};
          entry_pos          = '0;
          produced           = 1'b1;
        end else begin
          entry_buf = {entry_buf[15:0], b};
          entry_pos = entry_pos + 2'd1;
        end
        // End of the loop; a partial entry is simply dropped.
        if (group_left == 0) begin
          entry_pos = '0;
          hdr_pos   = '0;
          state     = ST_CH_HEAD;
        end
        return produced;
      end
      ST_RG_HEAD: begin
        // Region number, three skipped bytes, then the name length.
        if (hdr_pos == 3'd5) begin
          hdr_pos = '0;
          if (b > bytes_left) begin
            state = ST_SKIP;
            return 1'b0;
          end
          if (b == 0) begin
            rec.kind      = crdp_pkg::KIND_EMPTY;
            rec.region_id = region;
            rec.name_last = 1'b1;
            return 1'b1;
          end
          group_left = b;
          state      = ST_RG_NAME;
          return 1'b0;
        end
        if (hdr_pos == 3'd0) region = {b, 8'h00};
        else if (hdr_pos == 3'd1) region[7:0] = b;
        hdr_pos = hdr_pos + 3'd1;
        return 1'b0;
      end
      ST_RG_NAME: begin
        group_left    = group_left - 8'd1;
        rec.kind      = crdp_pkg::KIND_NAME;
        rec.region_id = region;
        rec.name_char = b;
        rec.name_last = (group_left == 0);
        if (group_left == 0) begin
          hdr_pos = '0;
          state   = ST_RG_HEAD;
        end
        return 1'b1;
      end
      default: begin
        state = ST_SKIP;
        return 1'b0;
      end
    endcase
  endfunction

  // Called for every accepted input request.
  function void note_request(desc_byte_t it);
    crdp_pkg::result_t rec;
    if (parse_byte(it, rec)) records_due.insert(records_due.size(), rec);
  endfunction

  function void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 50)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
    end
  endfunction

  // Called for every popped record.
  function void check_result(crdp_pkg::result_t got);
    crdp_pkg::result_t want;
    records_checked++;
    if (records_due.size() == 0) begin
      errors++;
      if (errors <= 50)
        $display("%0t ns: record popped with none expected, actual %p", $time, got);
      return;
    end
    want = records_due.pop_front();
    compare_field("record_kind", want.kind, got.kind);
    compare_field("service_id", want.service_id, got.service_id);
    compare_field("channel_number", want.channel_number, got.channel_number);
    compare_field("region_code", want.region_code, got.region_code);
    compare_field("region_id", want.region_id, got.region_id);
    compare_field("name_char", want.name_char, got.name_char);
    compare_field("name_last", want.name_last, got.name_last);
  endfunction
endclass

module tb_channel_region_descriptor_parser;

  localparam int unsigned ItemsPerPhase = 370;
  localparam int unsigned NumPhases     = 5;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_idx_i     = '0;
  logic [7:0]  cfg_data_i    = '0;
  logic        push          = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i   = '0;
  logic [7:0]  desc_tag_i    = '0;
  logic [7:0]  desc_length_i = '0;
  logic        first_byte_i  = 1'b0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [1:0]  record_kind_o;
  logic [15:0] service_id_o;
  logic [11:0] channel_number_o;
  logic [15:0] region_code_o;
  logic [15:0] region_id_o;
  logic [7:0]  name_char_o;
  logic        name_last_o;

  descriptor_scoreboard sb = new();

  logic [7:0]  body_q[$];
  int unsigned burst_left     = 0;
  int unsigned bytes_accepted = 0;
  int unsigned parsed_bytes   = 0;
  int unsigned tag_settings   = 1;

  channel_region_descriptor_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte_i),
    .desc_tag_i      (desc_tag_i),
    .desc_length_i   (desc_length_i),
    .first_byte_i    (first_byte_i),
    .empty           (empty),
    .pop             (pop),
    .record_kind_o   (record_kind_o),
    .service_id_o    (service_id_o),
    .channel_number_o(channel_number_o),
    .region_code_o   (region_code_o),
    .region_id_o     (region_id_o),
    .name_char_o     (name_char_o),
    .name_last_o     (name_last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watch both handshakes; values read here are the ones before the edge.
  always @(posedge clk_i) begin : handshake_monitor
    desc_byte_t        req;
    crdp_pkg::result_t got;
    if (rst_ni && push && !full) begin
      req = '{data: data_byte_i, tag: desc_tag_i, len: desc_length_i,
              first: first_byte_i};
      sb.note_request(req);
      bytes_accepted++;
    end
    if (rst_ni && pop && !empty) begin
      got.kind           = crdp_pkg::record_kind_e'(record_kind_o);
      got.service_id     = service_id_o;
      got.channel_number = channel_number_o;
      got.region_code    = region_code_o;
      got.region_id      = region_id_o;
      got.name_char      = name_char_o;
      got.name_last      = name_last_o;
      sb.check_result(got);
    end
  end

  // Receiver stall pattern: stretches of always-pop, light and heavy random
  // stalls, and a square wave.
  initial begin : pop_pattern
    int unsigned mode;
    int unsigned left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ((left % 8) < 4);
      endcase
    end
  end

  // Sends one request; returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] data, input logic [7:0] tag,
                           input logic [7:0] len, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    push          <= 1'b1;
    data_byte_i   <= data;
    desc_tag_i    <= tag;
    desc_length_i <= len;
    first_byte_i  <= first;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Sends body_q as one descriptor; tag and length are random after byte 0.
  task automatic send_body(input logic [7:0] tag, input int unsigned len);
    bit known;
    known = (tag == sb.channel_tag) || (tag == sb.region_tag);
    foreach (body_q[i]) begin
      if (i == 0) send_byte(body_q[i], tag, 8'(len), 1'b1);
      else send_byte(body_q[i], 8'($urandom), 8'($urandom), 1'b0);
      if (known && i < len) parsed_bytes++;
    end
  endtask

  // Stops sending and waits until every owed record has been popped, then
  // lets bytes that yield nothing clear the internal queues.
  task automatic wait_for_records();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write, after which the write port is left idle.
  task automatic write_reg(input crdp_pkg::reg_idx_e idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_tag(idx, value);
    @(posedge clk_i);
  endtask

  // Appends one byte to the descriptor body being built.
  function automatic void add_byte(input logic [7:0] value);
    body_q.insert(body_q.size(), value);
  endfunction

  // Channel group: service id, two skipped bytes, loop length, entries.
  // An overrun group states a loop longer than what follows it.
  function automatic void add_channel_group(bit overrun);
    int unsigned n_ent, tail, loop_len, k;
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    if (overrun) begin
      k        = $urandom_range(0, 6);
      loop_len = k + 1 + $urandom_range(0, 20);
    end else begin
      n_ent    = $urandom_range(0, 4);
      tail     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      loop_len = 4 * n_ent + tail;
      k        = loop_len;
    end
    add_byte(8'(loop_len));
    repeat (k) add_byte(8'($urandom));
  endfunction

  // Region group: region number, three skipped bytes, name length, name.
  function automatic void add_region_group(bit overrun);
    int unsigned name_len, k;
    repeat (5) add_byte(8'($urandom));
    if (overrun) begin
      k        = $urandom_range(0, 6);
      name_len = k + 1 + $urandom_range(0, 20);
    end else begin
      name_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      k        = name_len;
    end
    add_byte(8'(name_len));
    repeat (k) add_byte(8'($urandom));
  endfunction

  // One random descriptor: mostly well-formed channel or region lists, some
  // unknown tags, orphan bytes and zero-length starts.
  task automatic send_random_descriptor();
    int unsigned pick, target, len;
    bit          overrun, as_channel;
    logic [7:0]  tag;
    pick = $urandom_range(0, 19);
    body_q.delete();
    if (pick == 19) begin
      if ($urandom_range(0, 1) == 0) begin
        add_byte(8'($urandom));
        send_body(($urandom_range(0, 1) == 0) ? sb.channel_tag : sb.region_tag, 0);
      end
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      return;
    end
    if (pick >= 17) begin
      do tag = 8'($urandom);
      while (tag == sb.channel_tag || tag == sb.region_tag);
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      send_body(tag, body_q.size());
      return;
    end
    as_channel = (pick <= 8);
    tag        = as_channel ? sb.channel_tag : sb.region_tag;
    target     = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 250)
                                              : $urandom_range(1, 50);
    while (body_q.size() < target) begin
      overrun = ($urandom_range(0, 14) == 0);
      if (as_channel) add_channel_group(overrun);
      else add_region_group(overrun);
      if (overrun) break;
    end
    // Short tail: a header the descriptor cannot finish.
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    len = (body_q.size() > 255) ? 255 : body_q.size();
    // Now and then the stated length disagrees with the bytes sent.
    case ($urandom_range(0, 15))
      0: len = $urandom_range(0, len);
      1: len = $urandom_range(len, 255);
      default: ;
    endcase
    send_body(tag, len);
  endtask

  initial begin : stimulus
    logic [7:0] ch_tag, rg_tag;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a byte before any descriptor start.
    send_byte(8'hFF, 8'hFF, 8'hFF, 1'b0);
    // Zero-length descriptor followed by a byte past its end.
    body_q = '{8'h00, 8'h5A};
    send_body(crdp_pkg::ChannelTagReset, 0);
    // Channel list: all-ones entry, a partial entry byte, then a short tail.
    body_q = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h05,
               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E, 8'h12};
    send_body(crdp_pkg::ChannelTagReset, body_q.size());
    // Region list: one-character name, then a name longer than the rest.
    body_q = '{8'hFF, 8'hFF, 8'h44, 8'h55, 8'h66, 8'h01, 8'h5A,
               8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h07, 8'h61};
    send_body(crdp_pkg::RegionTagReset, body_q.size());

    // Random phases, each under its own pair of tags.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_for_records();
        case (p)
          1: begin ch_tag = 8'h00; rg_tag = 8'hFF; end
          2: begin ch_tag = 8'hFF; rg_tag = 8'h00; end
          3: begin ch_tag = 8'h5A; rg_tag = 8'h5A; end
          default: begin ch_tag = 8'($urandom); rg_tag = 8'($urandom); end
        endcase
        write_reg(crdp_pkg::REG_CHANNEL_TAG, ch_tag);
        write_reg(crdp_pkg::REG_REGION_TAG, rg_tag);
        tag_settings++;
      end
      while (parsed_bytes < ItemsPerPhase * (p + 1)) send_random_descriptor();
    end

    wait_for_records();
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0d expected records never arrived", sb.pending());
    $display("Sent %0d bytes (%0d inside recognized descriptors) under %0d tag settings;",
             bytes_accepted, parsed_bytes, tag_settings);
    $display("checked %0d records.", sb.records_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_channel_region_descriptor_parser: done, clean");
    end else begin
      $display("tb_channel_region_descriptor_parser: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d records still expected", sb.pending());
    $display("tb_channel_region_descriptor_parser: done, errors");
    $finish;
  end

endmodule
